// ----- rtl/core/assert_macros.svh -----
// Assertion macros shared by the RTL files; compiled out for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Antecedent in one cycle implies consequent in the next
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) else $error(msg);

// Antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, prop, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- rtl/core/asp_pkg.sv -----
// Types and constants of the Annex B SPS/PPS locator.
package asp_pkg;

  // Width of every index and size field on the result channel
  localparam int FIELD_W = 17;

  // Bytes of look-ahead before a position is examined
  localparam int LOOKAHEAD_BYTES = 4;

  // Start code lengths
  localparam int CODE_LEN_LONG  = 4;
  localparam int CODE_LEN_SHORT = 3;

  // Legal range of the summed start code lengths
  localparam int TOTAL_MIN = 9;
  localparam int TOTAL_MAX = 12;

  // Minimum SPS span: last index must be at least first + this
  localparam int SPS_MIN_SPAN = 4;

  // Number of start codes that ends the scan
  localparam logic [1:0] CODES_DONE = 2'd3;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_SPS_BAD   = 3'd1,
    ST_PPS_BAD   = 3'd2,
    ST_TOTAL_BAD = 3'd3,
    ST_TOO_LONG  = 3'd4
  } status_t;

endpackage

// ----- rtl/core/asp_if.sv -----
// Stream channels of the locator: byte input and boundary result.
interface asp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       last_byte;

  modport source (output valid, output frame_byte, output last_byte, input ready);
  modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface asp_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [16:0] sps_first;
  logic signed [16:0] sps_final;
  logic signed [16:0] pps_first;
  logic signed [16:0] pps_final;
  logic [16:0]        header_bytes;

  modport source (output valid, output status, output sps_first, output sps_final,
                  output pps_first, output pps_final, output header_bytes,
                  input ready);
  modport sink   (input valid, input status, input sps_first, input sps_final,
                  input pps_first, input pps_final, input header_bytes,
                  output ready);
endinterface

// ----- rtl/core/annexb_sps_pps_locator_top.sv -----
// Annex B start code scanner that locates the SPS and PPS of one H.264 key frame.
//
// Usage: in_ch carries the frame one byte per item, last_byte marking the final
// byte. For each frame exactly one item leaves on out_ch: a status code, the
// first/last index of the SPS and PPS (-1 where not found) and the header size.
// Items without last_byte produce nothing.
// Throughput: one byte per cycle while in_ch.ready is high, set by the four-byte
// window compare and the boundary update, which both sit in a single
// register-to-register stage. Result path: the capture register loads at the edge
// that accepts the last byte, and the status checks feed the output register once
// that register is free.
// Reset clears the scan state, the window and the valid flags of both result stages;
// boundaries reset to -1. After each last byte the scan state returns to that reset state.
// Stalls: the output register holds while out_ch.ready is low; the capture
// register behind it absorbs one more result, and in_ch.ready falls only when
// both are full, so bytes keep flowing while a result waits.
module annexb_sps_pps_locator_top #(
  parameter int MAX_FRAME_BYTES = 65536
) (
  input logic      clk,
  input logic      rst_n,
  asp_in_if.sink   in_ch,
  asp_out_if.source out_ch
);
  import asp_pkg::*;

  `include "assert_macros.svh"

  localparam int POS_W  = $clog2(MAX_FRAME_BYTES + 1);
  localparam int MARK_W = POS_W + 1;
  localparam int CMP_W  = MARK_W + 3;

  localparam logic [POS_W-1:0]         POS_MAX   = POS_W'(MAX_FRAME_BYTES);
  localparam logic [POS_W-1:0]         POS_LOOK  = POS_W'(LOOKAHEAD_BYTES);
  localparam logic signed [MARK_W-1:0] MARK_NONE = '1;

  typedef logic signed [MARK_W-1:0] mark_t;

  // Scan state
  logic [7:0]       win_r   [LOOKAHEAD_BYTES];
  logic [7:0]       win_nxt [LOOKAHEAD_BYTES];
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W-1:0] nexam_r, nexam_nxt;
  logic [1:0]       codes_r, codes_nxt;
  mark_t            sf_r, sf_nxt, se_r, se_nxt, pf_r, pf_nxt, pe_r, pe_nxt;
  logic [3:0]       tot_r, tot_nxt;
  logic             ovf_r, ovf_nxt;

  // Capture stage
  logic             fin_valid_r;
  mark_t            fin_sf_r, fin_se_r, fin_pf_r, fin_pe_r;
  logic [3:0]       fin_tot_r;
  logic             fin_ovf_r;

  // Output stage
  logic             out_valid_r;
  status_t          out_status_r;
  logic [FIELD_W-1:0] out_sf_r, out_se_r, out_pf_r, out_pe_r, out_hdr_r;

  logic             in_acc, out_free, fin_adv;
  logic [2:0]       code_len;
  logic [POS_W-1:0] ex_pos;
  logic             do_ex;
  mark_t            ex_end, ex_prev;

  // Handshake
  assign out_free = !out_valid_r || out_ch.ready;
  assign fin_adv  = fin_valid_r && out_free;
  assign in_ch.ready = !(fin_valid_r && !out_free);
  assign in_acc   = in_ch.valid && in_ch.ready;

  // Start code match on the window, oldest byte first
  always_comb begin
    code_len = 3'd0;
    if (win_r[0] == 8'h00 && win_r[1] == 8'h00 && win_r[2] == 8'h00 && win_r[3] == 8'h01) begin
      code_len = 3'(CODE_LEN_LONG);
    end else if (win_r[0] == 8'h00 && win_r[1] == 8'h00 && win_r[2] == 8'h01) begin
      code_len = 3'(CODE_LEN_SHORT);
    end
  end

  // Examined position trails the arriving byte by the look-ahead
  assign ex_pos  = pos_r - POS_LOOK;
  assign do_ex   = (pos_r != POS_MAX) && (pos_r >= POS_LOOK) && (ex_pos >= nexam_r) &&
                   (codes_r != CODES_DONE) && (code_len != 3'd0);
  assign ex_end  = mark_t'({1'b0, ex_pos + POS_W'(code_len)});
  assign ex_prev = mark_t'({1'b0, ex_pos}) - mark_t'(1);

  // Next scan state for an accepted byte
  always_comb begin
    win_nxt   = win_r;
    pos_nxt   = pos_r;
    nexam_nxt = nexam_r;
    codes_nxt = codes_r;
    sf_nxt    = sf_r;
    se_nxt    = se_r;
    pf_nxt    = pf_r;
    pe_nxt    = pe_r;
    tot_nxt   = tot_r;
    ovf_nxt   = ovf_r;
    if (pos_r == POS_MAX) begin
      ovf_nxt = 1'b1;
    end else begin
      if (do_ex) begin
        tot_nxt   = tot_r + 4'(code_len);
        codes_nxt = codes_r + 2'd1;
        case (codes_r)
          2'd0: begin
            sf_nxt    = ex_end;
            nexam_nxt = POS_W'(ex_end);
          end
          2'd1: begin
            se_nxt    = ex_prev;
            pf_nxt    = ex_end;
            nexam_nxt = POS_W'(ex_end);
          end
          default: begin
            pe_nxt = ex_prev;
          end
        endcase
      end
      for (int k = 0; k < LOOKAHEAD_BYTES - 1; k++) begin
        win_nxt[k] = win_r[k+1];
      end
      win_nxt[LOOKAHEAD_BYTES-1] = in_ch.frame_byte;
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  // Scan state registers; cleared after every last byte
  always_ff @(posedge clk) begin
    if (!rst_n || (in_acc && in_ch.last_byte)) begin
      for (int k = 0; k < LOOKAHEAD_BYTES; k++) begin
        win_r[k] <= 8'h00;
      end
      pos_r   <= '0;
      nexam_r <= '0;
      codes_r <= 2'd0;
      sf_r    <= MARK_NONE;
      se_r    <= MARK_NONE;
      pf_r    <= MARK_NONE;
      pe_r    <= MARK_NONE;
      tot_r   <= 4'd0;
      ovf_r   <= 1'b0;
    end else if (in_acc) begin
      win_r   <= win_nxt;
      pos_r   <= pos_nxt;
      nexam_r <= nexam_nxt;
      codes_r <= codes_nxt;
      sf_r    <= sf_nxt;
      se_r    <= se_nxt;
      pf_r    <= pf_nxt;
      pe_r    <= pe_nxt;
      tot_r   <= tot_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  // Capture stage: frame summary taken on the last byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_valid_r <= 1'b0;
    end else if (in_acc && in_ch.last_byte) begin
      fin_valid_r <= 1'b1;
    end else if (fin_adv) begin
      fin_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_ch.last_byte) begin
      fin_sf_r  <= sf_nxt;
      fin_se_r  <= se_nxt;
      fin_pf_r  <= pf_nxt;
      fin_pe_r  <= pe_nxt;
      fin_tot_r <= tot_nxt;
      fin_ovf_r <= ovf_nxt;
    end
  end

  // Status checks and header size
  logic signed [CMP_W-1:0] sf_x, se_x, pf_x, pe_x, tot_x, hdr_x;
  logic                    sps_bad, pps_bad, tot_bad;
  status_t                 status_c;

  assign sf_x  = CMP_W'(fin_sf_r);
  assign se_x  = CMP_W'(fin_se_r);
  assign pf_x  = CMP_W'(fin_pf_r);
  assign pe_x  = CMP_W'(fin_pe_r);
  assign tot_x = signed'(CMP_W'(fin_tot_r));

  assign sps_bad = (fin_sf_r == MARK_NONE) || (se_x < sf_x + CMP_W'(SPS_MIN_SPAN));
  assign pps_bad = (pf_x <= se_x) || (pf_x >= pe_x);
  assign tot_bad = (fin_tot_r < 4'(TOTAL_MIN)) || (fin_tot_r > 4'(TOTAL_MAX));
  assign hdr_x   = (se_x - sf_x + CMP_W'(1)) + (pe_x - pf_x + CMP_W'(1)) + tot_x;

  always_comb begin
    if (fin_ovf_r) begin
      status_c = ST_TOO_LONG;
    end else if (sps_bad) begin
      status_c = ST_SPS_BAD;
    end else if (pps_bad) begin
      status_c = ST_PPS_BAD;
    end else if (tot_bad) begin
      status_c = ST_TOTAL_BAD;
    end else begin
      status_c = ST_OK;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_adv) begin
      out_status_r <= status_c;
      out_sf_r     <= FIELD_W'(fin_sf_r);
      out_se_r     <= FIELD_W'(fin_se_r);
      out_pf_r     <= FIELD_W'(fin_pf_r);
      out_pe_r     <= FIELD_W'(fin_pe_r);
      out_hdr_r    <= (status_c == ST_OK) ? FIELD_W'(hdr_x) : '0;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.status       = out_status_r;
  assign out_ch.sps_first    = signed'(out_sf_r);
  assign out_ch.sps_final    = signed'(out_se_r);
  assign out_ch.pps_first    = signed'(out_pf_r);
  assign out_ch.pps_final    = signed'(out_pe_r);
  assign out_ch.header_bytes = out_hdr_r;

  // Checks
  `ASSERT_IMPLY(a_pe_after_third, clk, rst_n, codes_r != CODES_DONE, pe_r == MARK_NONE, "PPS end set before third start code")
  `ASSERT_ALWAYS(a_tot_range, clk, rst_n, tot_r <= 4'(TOTAL_MAX), "start code total above limit")
  `ASSERT_ALWAYS(a_pos_sat, clk, rst_n, pos_r <= POS_MAX, "position counter past saturation")
  `ASSERT_IMPLY(a_ovf_pos, clk, rst_n, ovf_r, pos_r == POS_MAX, "overflow flagged below saturation")
  `ASSERT_NEXT(a_fin_hold, clk, rst_n, fin_valid_r && !out_free, fin_valid_r, "captured result lost while output stalled")

endmodule

// ----- bench/tb.sv -----
// Self-checking bench for the Annex B SPS/PPS locator: predicts each frame's result and compares.
module tb;
  import asp_pkg::*;

  localparam int FRAME_LIMIT    = 65536;
  localparam int CLK_HALF       = 2;
  localparam int RESET_CYCLES   = 9;
  localparam int LATENCY_CYCLES = 8;
  localparam int TIMEOUT_CYCLES = 1500000;
  localparam int HOLD_CYCLES    = 300;

  typedef struct packed {
    logic [2:0]  status;
    logic [16:0] sps_first;
    logic [16:0] sps_final;
    logic [16:0] pps_first;
    logic [16:0] pps_final;
    logic [16:0] header_bytes;
  } frame_result_t;

  logic clk = 1'b0;
  logic rst_n;

  asp_in_if  in_ch();
  asp_out_if out_ch();

  annexb_sps_pps_locator_top #(.MAX_FRAME_BYTES(FRAME_LIMIT)) uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  always #(CLK_HALF) clk = ~clk;

  // Scan state of the predictor
  logic [7:0]    scan_window [LOOKAHEAD_BYTES];
  int unsigned   scan_pos;
  int unsigned   scan_from;
  int unsigned   codes_seen;
  int unsigned   code_total;
  int            marks [4];
  bit            frame_overflow;

  frame_result_t expected_results [$];
  logic [7:0]    frame_buf [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_request  = 0;
  int bytes_sent    = 0;
  int errors        = 0;

  task automatic clear_scan_state();
    foreach (scan_window[k]) scan_window[k] = 8'h00;
    scan_pos       = 0;
    scan_from      = 0;
    codes_seen     = 0;
    code_total     = 0;
    foreach (marks[k]) marks[k] = -1;
    frame_overflow = 1'b0;
  endtask

  // Advance the scan by one accepted byte; on the last byte queue the frame's result
  task automatic scan_byte(input logic [7:0] b, input logic last);
    int unsigned   at;
    int unsigned   len;
    int            sf, se, pf, pe;
    int unsigned   hdr;
    status_t       st;
    frame_result_t r;
    if (scan_pos >= FRAME_LIMIT) begin
      // byte dropped, position saturates
      frame_overflow = 1'b1;
    end else begin
      if (scan_pos >= LOOKAHEAD_BYTES) begin
        at  = scan_pos - LOOKAHEAD_BYTES;
        len = 0;
        if (codes_seen < CODES_DONE && at >= scan_from) begin
          if (scan_window[0] == 8'h00 && scan_window[1] == 8'h00 &&
              scan_window[2] == 8'h00 && scan_window[3] == 8'h01) begin
            len = CODE_LEN_LONG;
          end else if (scan_window[0] == 8'h00 && scan_window[1] == 8'h00 &&
                       scan_window[2] == 8'h01) begin
            len = CODE_LEN_SHORT;
          end
        end
        if (len != 0) begin
          code_total += len;
          if (codes_seen == 0) begin
            marks[0]  = at + len;
            scan_from = at + len;
          end else if (codes_seen == 1) begin
            marks[1]  = at - 1;
            marks[2]  = at + len;
            scan_from = at + len;
          end else begin
            marks[3] = at - 1;
          end
          codes_seen++;
        end
      end
      for (int k = 0; k < LOOKAHEAD_BYTES - 1; k++) scan_window[k] = scan_window[k + 1];
      scan_window[LOOKAHEAD_BYTES - 1] = b;
      scan_pos++;
    end

    if (last) begin
      sf = marks[0];
      se = marks[1];
      pf = marks[2];
      pe = marks[3];
      // overflow first, then SPS, PPS and code total in that order
      if (frame_overflow) st = ST_TOO_LONG;
      else if (sf == -1 || se < sf + SPS_MIN_SPAN) st = ST_SPS_BAD;
      else if (pf <= se || pf >= pe) st = ST_PPS_BAD;
      else if (code_total < TOTAL_MIN || code_total > TOTAL_MAX) st = ST_TOTAL_BAD;
      else st = ST_OK;
      hdr = 0;
      if (st == ST_OK) hdr = (se - sf + 1) + (pe - pf + 1) + code_total;
      r.status       = st;
      r.sps_first    = sf[16:0];
      r.sps_final    = se[16:0];
      r.pps_first    = pf[16:0];
      r.pps_final    = pe[16:0];
      r.header_bytes = hdr[16:0];
      expected_results = {expected_results, r};
      clear_scan_state();
    end
  endtask

  // Result check against the oldest expectation
  always @(posedge clk) begin : result_check
    frame_result_t got;
    frame_result_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      got.status       = out_ch.status;
      got.sps_first    = out_ch.sps_first;
      got.sps_final    = out_ch.sps_final;
      got.pps_first    = out_ch.pps_first;
      got.pps_final    = out_ch.pps_final;
      got.header_bytes = out_ch.header_bytes;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: status %0d sps %0d..%0d pps %0d..%0d header %0d",
                 $time, got.status, $signed(got.sps_first), $signed(got.sps_final),
                 $signed(got.pps_first), $signed(got.pps_final), got.header_bytes);
      end else begin
        want = expected_results.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: mismatch: expected status %0d sps %0d..%0d pps %0d..%0d header %0d",
                   $time, want.status, $signed(want.sps_first), $signed(want.sps_final),
                   $signed(want.pps_first), $signed(want.pps_final), want.header_bytes);
          $display("%0t:           actual status %0d sps %0d..%0d pps %0d..%0d header %0d",
                   $time, got.status, $signed(got.sps_first), $signed(got.sps_final),
                   $signed(got.pps_first), $signed(got.pps_final), got.header_bytes);
        end
      end
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested
  initial begin : receiver
    int n;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        n            = hold_request;
        hold_request = 0;
        out_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
    end
  end

  // Offer one byte, starting and ending at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.frame_byte <= b;
    in_ch.last_byte  <= last;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    scan_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    foreach (frame_buf[i]) send_byte(frame_buf[i], i == frame_buf.size() - 1);
  endtask

  // Sender goes quiet until every queued result has arrived
  task automatic wait_for_results();
    in_ch.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
  endtask

  // Append one byte to the frame being built
  task automatic add_byte(input logic [7:0] b);
    frame_buf = {frame_buf, b};
  endtask

  // Payload byte biased towards the start code values
  function automatic logic [7:0] body_byte();
    case ($urandom_range(9, 0)) inside
      0, 1: return 8'h00;
      2: return 8'h01;
      default: return 8'($urandom_range(255, 0));
    endcase
  endfunction

  task automatic push_start_code();
    if ($urandom_range(1, 0) == 1) add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h00);
    add_byte(8'h01);
  endtask

  // Mostly well-formed frames; some noise, some with a code missing or cut short
  task automatic send_random_frame();
    int pick;
    int drop;
    int n;
    frame_buf.delete();
    pick = $urandom_range(99, 0);
    if (pick < 12) begin
      n = $urandom_range(30, 1);
      repeat (n) add_byte(pick < 6 ? body_byte() : 8'($urandom_range(255, 0)));
    end else begin
      drop = (pick < 24) ? $urandom_range(2, 0) : -1;
      n = $urandom_range(3, 0);
      repeat (n) add_byte(8'($urandom_range(255, 2)));
      for (int c = 0; c < 3; c++) begin
        if (c != drop) push_start_code();
        if (c == 0) n = $urandom_range(10, 2);
        else if (c == 1) n = $urandom_range(6, 1);
        else n = $urandom_range(6, 0);
        repeat (n) add_byte($urandom_range(3, 0) == 0 ? body_byte() :
                            8'($urandom_range(255, 2)));
      end
      // truncated frame
      if (pick >= 24 && pick < 32) begin
        n = $urandom_range(frame_buf.size(), 1);
        while (frame_buf.size() > n) void'(frame_buf.pop_back());
      end
    end
    send_frame();
  endtask

  // Short frames and one minimal good frame, with both byte extremes
  task automatic test_directed_frames();
    frame_buf = '{8'hFF};
    send_frame();
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h01};
    send_frame();
    frame_buf = '{8'h00, 8'h00, 8'h00, 8'h01, 8'h67, 8'h42, 8'hC0, 8'h1F, 8'h9A,
                  8'h00, 8'h00, 8'h01, 8'h68, 8'hCE,
                  8'h00, 8'h00, 8'h01, 8'h65, 8'hFF};
    send_frame();
  endtask

  task automatic test_random_frames(input int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_frame();
  endtask

  // Receiver holds off while short frames keep coming, so the block fills and stalls
  task automatic test_output_backpressure();
    hold_request = HOLD_CYCLES;
    repeat (30) begin
      frame_buf.delete();
      repeat (5) add_byte(body_byte());
      send_frame();
    end
  endtask

  // Sender stops until every result is in, then carries on
  task automatic test_pause_for_drain();
    repeat (4) send_random_frame();
    wait_for_results();
    repeat (4) send_random_frame();
  endtask

  // Abort on a hang
  initial begin : watchdog
    #(TIMEOUT_CYCLES * 2 * CLK_HALF);
    $display("Regression FAIL");
    $finish;
  end

  initial begin : main_sequence
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.frame_byte = 8'h00;
    in_ch.last_byte  = 1'b0;
    clear_scan_state();
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(6, 64);
    test_directed_frames();
    test_random_frames(520);
    wait_for_results();

    set_idling(64, 6);
    test_random_frames(520);
    wait_for_results();

    set_idling(0, 0);
    test_random_frames(520);
    test_output_backpressure();
    wait_for_results();
    test_pause_for_drain();

    wait_for_results();
    repeat (LATENCY_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
